// ===== sv/modular_square_root_assert.svh =====
// Assertion macros shared by the modular square root RTL.
// Each macro expects clk and rst to be in scope.
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/msr_pkg.sv =====
// ----------------------------------------------------------------------------
// msr_pkg
// Sequencer state and multiplier destination codes for the modular square
// root block.
// ----------------------------------------------------------------------------
package msr_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_CHKP, S_REDZ, S_ZERO, S_POW, S_POWSQ, S_EULER, S_FACTOR,
    S_GOTC, S_GOTT, S_GOTR, S_LOOP, S_SEARCH, S_SQB, S_UPDT, S_UPDR,
    S_SETR, S_FINAL, S_FINCHK, S_WAIT, S_DONE
  } state_t;

  // where a finished product is written
  typedef enum logic [3:0] {
    D_NONE, D_N, D_Z, D_ACC, D_SQ, D_B, D_C, D_T, D_R
  } dest_t;

endpackage

// ===== sv/msr_mulmod.sv =====
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of a per cycle, MSB
// first, with interleaved reduction. b must already be below m.
// ----------------------------------------------------------------------------
module msr_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] prod
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_sh;
  logic [W-1:0]  b_reg;
  logic [W-1:0]  m_reg;
  logic [CW-1:0] cnt;
  logic [W+1:0]  sum;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W-1:0]  red;

  // double, add, and reduce (sum stays below 3m)
  always_comb begin
    m1  = {2'b00, m_reg};
    m2  = {1'b0, m_reg, 1'b0};
    sum = {1'b0, prod, 1'b0} + (a_sh[W-1] ? {2'b00, b_reg} : '0);
    if (sum >= m2) begin
      red = W'(sum - m2);
    end else if (sum >= m1) begin
      red = W'(sum - m1);
    end else begin
      red = sum[W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      b_reg <= b;
      m_reg <= m;
      prod  <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[W-2:0], 1'b0};
      prod <= red;
    end
  end

`include "modular_square_root_assert.svh"
  `MSR_ASSERT_IMPL(a_prod_reduced, done, prod < m_reg, "product not reduced")
  `MSR_ASSERT_NEXT(a_start_busy, start, busy && !done, "start did not begin a pass")

endmodule

// ===== sv/modular_square_root.sv =====
// Modular square root by Tonelli-Shanks over one WORD_BITS word.
// Each modular multiply runs in the one shared bit-serial multiplier; an exponentiation
// is up to 2*WORD_BITS multiplies. A prime 3 mod 4 takes 2 exponentiations; otherwise
// 4 plus the loop.
// Throughput: one item at a time; in_stall is high from accept until done.
// Reset: synchronous active-high rst returns the sequencer to idle, no output.
module modular_square_root
  import msr_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] residue,
  input  logic [31:0] prime,
  input  logic [31:0] nonresidue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] root,
  output logic        not_square
);
  localparam int W  = WORD_BITS;
  localparam int KW = $clog2(W + 1);

  state_t state, state_next, mret, mret_next, pret, pret_next;
  dest_t  dst, dst_next;

  logic [W-1:0]  p, p_next, nraw, nraw_next, zraw, zraw_next;
  logic [W-1:0]  n, n_next, z, z_next, q, q_next;
  logic [W-1:0]  c, c_next, t, t_next, r, r_next, b, b_next;
  logic [W-1:0]  acc, acc_next, sq, sq_next, expo, expo_next;
  logic [KW-1:0] s, s_next, m, m_next, i, i_next, j, j_next, k, k_next;
  logic [W-1:0]  res_root, res_root_next;
  logic          res_ns, res_ns_next;

  logic          mul_start, mul_busy, mul_done;
  logic [W-1:0]  mul_a, mul_b, mul_prod;

  logic [W:0]    p_inc, q_inc;
  logic [KW:0]   jil;
  logic          out_free;

  assign p_inc    = {1'b0, p} + (W+1)'(1);
  assign q_inc    = {1'b0, q} + (W+1)'(1);
  assign jil      = {1'b0, j} + {1'b0, i} + (KW+1)'(1);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  msr_mulmod #(.W(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .m    (p),
    .busy (mul_busy),
    .done (mul_done),
    .prod (mul_prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_CHKP;
      S_CHKP:   state_next = (p < W'(3) || !p[0]) ? S_DONE : S_WAIT;
      S_REDZ:   state_next = S_WAIT;
      S_ZERO:   state_next = (n == '0) ? S_DONE : S_POW;
      S_POW: begin
        if (k == KW'(W))    state_next = pret;
        else if (expo[k[$clog2(W)-1:0]]) state_next = S_WAIT;
        else                state_next = S_POWSQ;
      end
      S_POWSQ:  state_next = S_WAIT;
      S_EULER: begin
        if (acc != W'(1))          state_next = S_DONE;
        else if (p[1:0] == 2'b11)  state_next = S_POW;
        else                       state_next = S_FACTOR;
      end
      S_FACTOR: if (q[0]) state_next = S_POW;
      S_GOTC:   state_next = S_POW;
      S_GOTT:   state_next = S_POW;
      S_GOTR:   state_next = S_LOOP;
      S_LOOP:   state_next = (t == W'(1)) ? S_FINAL : S_SEARCH;
      S_SEARCH: begin
        if (b != W'(1) && i < m) state_next = S_WAIT;
        else if (i >= m)         state_next = S_DONE;
        else                     state_next = S_SQB;
      end
      S_SQB:    state_next = S_WAIT;
      S_UPDT:   state_next = S_WAIT;
      S_UPDR:   state_next = S_WAIT;
      S_SETR:   state_next = S_FINAL;
      S_FINAL:  state_next = S_WAIT;
      S_FINCHK: state_next = S_DONE;
      S_WAIT:   if (mul_done) state_next = mret;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and multiplier control
  always_comb begin
    p_next = p; nraw_next = nraw; zraw_next = zraw; n_next = n; z_next = z;
    q_next = q; c_next = c; t_next = t; r_next = r; b_next = b;
    acc_next = acc; sq_next = sq; expo_next = expo;
    s_next = s; m_next = m; i_next = i; j_next = j; k_next = k;
    res_root_next = res_root; res_ns_next = res_ns;
    mret_next = mret; pret_next = pret; dst_next = dst;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    case (state)
      S_IDLE: begin
        p_next    = prime[W-1:0];
        nraw_next = residue[W-1:0];
        zraw_next = nonresidue[W-1:0];
      end
      S_CHKP: begin
        res_root_next = '0;
        res_ns_next   = 1'b1;
        mul_start = !(p < W'(3) || !p[0]);
        mul_a = nraw; mul_b = W'(1); dst_next = D_N; mret_next = S_REDZ;
      end
      S_REDZ: begin
        mul_start = 1'b1;
        mul_a = zraw; mul_b = W'(1); dst_next = D_Z; mret_next = S_ZERO;
      end
      S_ZERO: begin
        res_root_next = '0;
        res_ns_next   = 1'b0;
        acc_next = W'(1); sq_next = n; expo_next = {1'b0, p[W-1:1]};
        k_next = '0; pret_next = S_EULER;
      end
      S_POW: begin
        mul_start = (k != KW'(W)) && expo[k[$clog2(W)-1:0]];
        mul_a = acc; mul_b = sq; dst_next = D_ACC; mret_next = S_POWSQ;
      end
      S_POWSQ: begin
        mul_start = 1'b1;
        mul_a = sq; mul_b = sq; dst_next = D_SQ; mret_next = S_POW;
        k_next = k + KW'(1);
      end
      S_EULER: begin
        res_root_next = '0;
        res_ns_next   = 1'b1;
        acc_next = W'(1); sq_next = n; k_next = '0;
        expo_next = W'(p_inc[W:2]); pret_next = S_SETR;
        q_next = p - W'(1); s_next = '0;
      end
      S_FACTOR: begin
        if (!q[0]) begin
          q_next = {1'b0, q[W-1:1]};
          s_next = s + KW'(1);
        end else begin
          m_next = s;
          acc_next = W'(1); sq_next = z; expo_next = q; k_next = '0;
          pret_next = S_GOTC;
        end
      end
      S_GOTC: begin
        c_next = acc;
        acc_next = W'(1); sq_next = n; expo_next = q; k_next = '0;
        pret_next = S_GOTT;
      end
      S_GOTT: begin
        t_next = acc;
        acc_next = W'(1); sq_next = n; expo_next = q_inc[W:1]; k_next = '0;
        pret_next = S_GOTR;
      end
      S_GOTR: r_next = acc;
      S_LOOP: begin
        i_next = '0;
        b_next = t;
      end
      S_SEARCH: begin
        res_root_next = '0;
        res_ns_next   = 1'b1;
        if (b != W'(1) && i < m) begin
          i_next = i + KW'(1);
          mul_start = 1'b1;
          mul_a = b; mul_b = b; dst_next = D_B; mret_next = S_SEARCH;
        end else begin
          b_next = c;
          j_next = '0;
        end
      end
      S_SQB: begin
        mul_start = 1'b1;
        mul_a = b; mul_b = b;
        if (jil < {1'b0, m}) begin
          j_next = j + KW'(1);
          dst_next = D_B; mret_next = S_SQB;
        end else begin
          m_next = i;
          dst_next = D_C; mret_next = S_UPDT;
        end
      end
      S_UPDT: begin
        mul_start = 1'b1;
        mul_a = t; mul_b = c; dst_next = D_T; mret_next = S_UPDR;
      end
      S_UPDR: begin
        mul_start = 1'b1;
        mul_a = r; mul_b = b; dst_next = D_R; mret_next = S_LOOP;
      end
      S_SETR: r_next = acc;
      S_FINAL: begin
        mul_start = 1'b1;
        mul_a = r; mul_b = r; dst_next = D_NONE; mret_next = S_FINCHK;
      end
      S_FINCHK: begin
        res_root_next = (mul_prod != n) ? '0 : r;
        res_ns_next   = (mul_prod != n);
      end
      S_WAIT: begin
        if (mul_done) begin
          case (dst)
            D_N:     n_next   = mul_prod;
            D_Z:     z_next   = mul_prod;
            D_ACC:   acc_next = mul_prod;
            D_SQ:    sq_next  = mul_prod;
            D_B:     b_next   = mul_prod;
            D_C:     c_next   = mul_prod;
            D_T:     t_next   = mul_prod;
            D_R:     r_next   = mul_prod;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p <= p_next; nraw <= nraw_next; zraw <= zraw_next; n <= n_next; z <= z_next;
    q <= q_next; c <= c_next; t <= t_next; r <= r_next; b <= b_next;
    acc <= acc_next; sq <= sq_next; expo <= expo_next;
    s <= s_next; m <= m_next; i <= i_next; j <= j_next; k <= k_next;
    res_root <= res_root_next; res_ns <= res_ns_next;
    mret <= mret_next; pret <= pret_next; dst <= dst_next;
    if (state == S_DONE && out_free) begin
      root       <= 32'(res_root);
      not_square <= res_ns;
    end
  end

`include "modular_square_root_assert.svh"
  `MSR_ASSERT_IMPL(a_mul_idle, mul_start, !mul_busy, "multiply launched while busy")
  `MSR_ASSERT_IMPL(a_err_zero, out_valid && not_square, root == 32'd0, "error word has root")
  `MSR_ASSERT_IMPL(a_done_wait, mul_done, state == S_WAIT, "product arrived outside wait")

endmodule
